FILE: rtl/core/umdt_pkg.sv
// umdt_pkg: shared constants, transaction types and helpers for the upstream trace block
// no dependencies; used by umdt_pick and upstream_max_discharge_trace
`default_nettype none

package umdt_pkg;

    localparam int CELL_W = 17;
    localparam int IDX_W  = 16;
    localparam int SLOTS  = 8;
    localparam int SLOT_W = 3;
    localparam int DIS_W  = 32;
    localparam int GID_W  = 32;

    // number of grid cells, cells are numbered 1..CELLS
    localparam logic [CELL_W-1:0] CELLS = 17'h10000;

    localparam logic [1:0] CMD_WR_INFLOW   = 2'd0;
    localparam logic [1:0] CMD_WR_DISCHARGE = 2'd1;
    localparam logic [1:0] CMD_WR_GLOBAL_ID = 2'd2;
    localparam logic [1:0] CMD_TRACE        = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CELL_W-1:0] cell_req;
        logic [SLOT_W-1:0] slot;
        logic [CELL_W-1:0] neighbour;
        logic [31:0]       value;
    } item_t;

    typedef struct packed {
        logic [CELL_W-1:0] spring_cell;
        logic [GID_W-1:0]  spring_global_id;
        logic              global_id_valid;
        logic [CELL_W-1:0] step_count;
        logic              loop_error;
    } result_t;

    // control from the sequencer to the neighbour pick unit
    typedef struct packed {
        logic clear;
        logic cand;
    } pick_ctrl_t;

    function automatic logic in_range(input logic [CELL_W-1:0] c);
        in_range = (c != '0) && (c <= CELLS);
    endfunction

    // table row of a cell in 1..CELLS
    function automatic logic [IDX_W-1:0] cell_idx(input logic [CELL_W-1:0] c);
        logic [CELL_W-1:0] d;
        d = c - 17'd1;
        cell_idx = d[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/umdt_ram.sv
// umdt_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module umdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/umdt_pick.sv
// umdt_pick: shared compare unit that scans inflow neighbours one at a time
// depends on umdt_pkg
`default_nettype none

module umdt_pick (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire umdt_pkg::pick_ctrl_t           ctrl,
    input  wire logic [umdt_pkg::CELL_W-1:0]    cur_cell,
    input  wire logic [umdt_pkg::CELL_W-1:0]    cand_cell,
    input  wire logic [umdt_pkg::DIS_W-1:0]     cand_dis,
    output logic      [umdt_pkg::CELL_W-1:0]    next_cell
);

    // count saturates at two: only none / one / several matters
    logic [1:0]                    count_reg, count_next;
    logic [umdt_pkg::CELL_W-1:0]   only_reg, only_next;
    logic [umdt_pkg::CELL_W-1:0]   best_reg, best_next;
    logic [umdt_pkg::DIS_W-1:0]    bestd_reg, bestd_next;

    always_comb
    begin
        count_next = count_reg;
        only_next  = only_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        if (ctrl.clear)
        begin
            count_next = 2'd0;
            best_next  = cur_cell;
            bestd_next = '0;
        end
        else if (ctrl.cand)
        begin
            if (count_reg != 2'd2)
            begin
                count_next = count_reg + 2'd1;
            end
            only_next = cand_cell;
            // strict compare keeps the lowest slot on ties
            if (cand_dis > bestd_reg)
            begin
                best_next  = cand_cell;
                bestd_next = cand_dis;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        only_reg  <= only_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
    end

    always_comb
    begin
        case (count_reg)
            2'd0:    next_cell = cur_cell;
            2'd1:    next_cell = only_reg;
            default: next_cell = best_reg;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/upstream_max_discharge_trace.sv
// upstream_max_discharge_trace: top level, table memories and the walk sequencer
// depends on umdt_pkg, umdt_ram and umdt_pick
`default_nettype none

// Holds an inflow table (eight neighbour slots per cell), a discharge table and a
// global id table for cells 1..65536, loaded by write transactions, and answers a
// trace transaction with the spring cell reached by walking upstream along the
// single inflow, or the inflow of largest positive discharge. Writes can follow
// back to back; writes to cells outside the grid are dropped and give no result.
// During a trace each visited cell reads its eight inflow slots one per cycle
// through the single read port of the inflow memory, each neighbour's discharge
// in the cycle after its inflow word, and a decide state then chooses the move.
// A walk of more than 65536 moves stops with loop_error. Tables come up undefined
// after reset and need no clearing pass; reading a never written entry gives
// arbitrary data. A finished result waits in an output register, and new
// transactions are taken meanwhile.
module upstream_max_discharge_trace (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire umdt_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output umdt_pkg::result_t      result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_GID    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam int INF_AW = umdt_pkg::IDX_W + umdt_pkg::SLOT_W;

    logic [2:0]                  state_reg, state_next;
    logic [umdt_pkg::CELL_W-1:0] cur_reg, cur_next;
    logic [umdt_pkg::CELL_W-1:0] step_reg, step_next;
    logic                        err_reg, err_next;
    // slot issue counter, bit 3 set once all eight slots are issued
    logic [umdt_pkg::SLOT_W:0]   issue_cnt_reg, issue_cnt_next;
    logic                        s1_vld_reg;
    logic                        s2_vld_reg;
    logic [umdt_pkg::CELL_W-1:0] s2_nb_reg;
    umdt_pkg::result_t           result_reg, result_next;
    logic                        result_valid_reg, result_valid_next;

    logic                        accept;
    logic                        issue;
    logic                        scan_done;
    logic                        cell_ok;
    logic [umdt_pkg::IDX_W-1:0]  wr_idx;
    logic [umdt_pkg::IDX_W-1:0]  cur_idx;

    logic [umdt_pkg::CELL_W-1:0] inf_rdata;
    logic [umdt_pkg::DIS_W-1:0]  dis_rdata;
    logic [umdt_pkg::GID_W-1:0]  gid_rdata;
    logic [umdt_pkg::CELL_W-1:0] pick_next;
    umdt_pkg::pick_ctrl_t        pick_ctrl;
    logic                        cur_ok;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign cell_ok = umdt_pkg::in_range(item.cell_req);
    assign wr_idx  = umdt_pkg::cell_idx(item.cell_req);
    assign cur_idx = umdt_pkg::cell_idx(cur_reg);
    assign cur_ok  = umdt_pkg::in_range(cur_reg);

    // ---------------- table memories ----------------
    // inflow rows are eight consecutive words, slot in the low address bits
    umdt_ram #(
        .WIDTH (umdt_pkg::CELL_W),
        .DEPTH (umdt_pkg::SLOTS << umdt_pkg::IDX_W)
    ) u_inflow_ram (
        .clk   (clk),
        .we    (accept && (item.cmd == umdt_pkg::CMD_WR_INFLOW) && cell_ok),
        .waddr ({wr_idx, item.slot}),
        .wdata (item.neighbour),
        .raddr (INF_AW'({cur_idx, issue_cnt_reg[umdt_pkg::SLOT_W-1:0]})),
        .rdata (inf_rdata)
    );

    // discharge is read for the neighbour that just came out of the inflow memory
    umdt_ram #(
        .WIDTH (umdt_pkg::DIS_W),
        .DEPTH (1 << umdt_pkg::IDX_W)
    ) u_discharge_ram (
        .clk   (clk),
        .we    (accept && (item.cmd == umdt_pkg::CMD_WR_DISCHARGE) && cell_ok),
        .waddr (wr_idx),
        .wdata (item.value),
        .raddr (umdt_pkg::cell_idx(inf_rdata)),
        .rdata (dis_rdata)
    );

    umdt_ram #(
        .WIDTH (umdt_pkg::GID_W),
        .DEPTH (1 << umdt_pkg::IDX_W)
    ) u_global_id_ram (
        .clk   (clk),
        .we    (accept && (item.cmd == umdt_pkg::CMD_WR_GLOBAL_ID) && cell_ok),
        .waddr (wr_idx),
        .wdata (item.value),
        .raddr (cur_idx),
        .rdata (gid_rdata)
    );

    // ---------------- neighbour scan pipeline ----------------
    // issue: slot address, s1: inflow word back, s2: discharge back and compared
    assign issue     = (state_reg == S_SCAN) && !issue_cnt_reg[umdt_pkg::SLOT_W];
    assign scan_done = (state_reg == S_SCAN) && issue_cnt_reg[umdt_pkg::SLOT_W]
                       && !s1_vld_reg && !s2_vld_reg;

    // clear on the first issue; candidates show up at s2, after the s1 inflow read
    assign pick_ctrl.clear = issue && (issue_cnt_reg == '0);
    assign pick_ctrl.cand  = s2_vld_reg && (s2_nb_reg != '0);

    umdt_pick u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (pick_ctrl),
        .cur_cell  (cur_reg),
        .cand_cell (s2_nb_reg),
        // a neighbour off the grid counts as zero discharge
        .cand_dis  (umdt_pkg::in_range(s2_nb_reg) ? dis_rdata : '0),
        .next_cell (pick_next)
    );

    // ---------------- walk sequencer ----------------
    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        step_next         = step_reg;
        err_next          = err_reg;
        issue_cnt_next    = issue_cnt_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.cmd == umdt_pkg::CMD_TRACE))
                begin
                    cur_next       = item.cell_req;
                    step_next      = '0;
                    err_next       = 1'b0;
                    issue_cnt_next = '0;
                    // a start off the grid ends at once
                    state_next     = cell_ok ? S_SCAN : S_GID;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (pick_next == cur_reg)
                begin
                    state_next = S_GID;
                end
                else if (step_reg == umdt_pkg::CELLS)
                begin
                    // step limit hit with a move still open
                    err_next   = 1'b1;
                    state_next = S_GID;
                end
                else
                begin
                    cur_next       = pick_next;
                    step_next      = step_reg + 1'b1;
                    issue_cnt_next = '0;
                    // a cell off the grid has no inflow, so the walk ends there
                    state_next     = umdt_pkg::in_range(pick_next) ? S_SCAN : S_GID;
                end
            end
            S_GID:
            begin
                // global id read of the spring cell lands next cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.spring_cell      = cur_reg;
                    result_next.spring_global_id = cur_ok ? gid_rdata : '0;
                    result_next.global_id_valid  = cur_ok;
                    result_next.step_count       = step_reg;
                    result_next.loop_error       = err_reg;
                    result_valid_next            = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issue_cnt_reg    <= '0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_cnt_reg    <= issue_cnt_next;
            s1_vld_reg       <= issue;
            s2_vld_reg       <= s1_vld_reg;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        step_reg   <= step_next;
        err_reg    <= err_next;
        s2_nb_reg  <= inf_rdata;
        result_reg <= result_next;
    end

    // ---------------- assertions ----------------
    // a compare stage only follows an inflow read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("compare stage without inflow read");

    // a loop error only comes with the full step count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.loop_error)
        |-> (result_reg.step_count == umdt_pkg::CELLS))
        else $error("loop error below step limit");

    // spring off the grid reports a zero global id
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.global_id_valid)
        |-> (result_reg.spring_global_id == '0))
        else $error("global id set for cell off the grid");

    // the scan never leaves with reads still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("decision taken with scan reads pending");

endmodule

`default_nettype wire

FILE: tb/upstream_max_discharge_trace_test.sv
// upstream_max_discharge_trace_test: self-checking testbench for the upstream spring trace block
// depends on umdt_pkg and upstream_max_discharge_trace; standalone, no files read
`default_nettype none

module upstream_max_discharge_trace_test;

    import umdt_pkg::*;

    // generous bound: the deliberate loop trace alone walks 65536 moves
    localparam int CYCLE_LIMIT = 4000000;
    localparam int POOL_N      = 14;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CELL_W-1:0] OFF_GRID = 17'h10000;

    typedef enum logic [1:0] {ENT_ITEM, ENT_DRAIN, ENT_HOLD} entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        item_t       it;
    } pending_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // transactions waiting to be offered, with drain and hold markers mixed in
    pending_t pend_q[$];
    // spring results the block still owes, oldest first
    result_t  springs_due[$];

    // shadow copy of the three tables, filled as writes are accepted
    logic [CELL_W-1:0] inflow_mem    [int];
    logic [DIS_W-1:0]  discharge_mem [int];
    logic [GID_W-1:0]  gid_mem       [int];

    // cells that traces may visit; every table entry of these is written first
    logic [CELL_W-1:0] pool [POOL_N];

    int      mismatches  = 0;
    int      cycle_count = 0;
    int      send_gap    = 0;
    int      stall_left  = 0;
    int      hold_asks   = 0;
    int      hold_served = 0;
    logic    nxt_valid;
    result_t want;

    upstream_max_discharge_trace uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic on_grid(input logic [CELL_W-1:0] c);
        return (c != '0) && (c <= CELLS);
    endfunction

    function automatic logic [CELL_W-1:0] slot_of(input logic [CELL_W-1:0] c, input int s);
        int key;
        key = (int'(c) - 1) * SLOTS + s;
        return inflow_mem.exists(key) ? inflow_mem[key] : '0;
    endfunction

    // one step upstream; returns c itself when the walk ends at c
    function automatic logic [CELL_W-1:0] upstream_of(input logic [CELL_W-1:0] c);
        int                n_in;
        logic [CELL_W-1:0] nb;
        logic [CELL_W-1:0] lone;
        logic [CELL_W-1:0] pick;
        logic [DIS_W-1:0]  q;
        logic [DIS_W-1:0]  top;
        if (!on_grid(c))
            return c;
        n_in = 0;
        lone = '0;
        pick = c;
        top  = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            nb = slot_of(c, j);
            if (nb != '0)
            begin
                n_in++;
                lone = nb;
            end
        end
        if (n_in == 0)
            return c;
        if (n_in == 1)
            return lone;
        // several inflows: largest positive discharge, strict compare keeps the lowest slot
        for (int j = 0; j < SLOTS; j++)
        begin
            nb = slot_of(c, j);
            if (nb != '0)
            begin
                q = (on_grid(nb) && discharge_mem.exists(int'(nb))) ?
                    discharge_mem[int'(nb)] : '0;
                if (q > top)
                begin
                    top  = q;
                    pick = nb;
                end
            end
        end
        return pick;
    endfunction

    function automatic result_t trace_spring(input logic [CELL_W-1:0] start);
        result_t           r;
        logic [CELL_W-1:0] here;
        logic [CELL_W-1:0] ahead;
        int                moves;
        logic              looped;
        here   = start;
        moves  = 0;
        looped = 1'b0;
        while (1'b1)
        begin
            ahead = upstream_of(here);
            if (ahead == here)
                break;
            // step limit reached while a move is still possible
            if (moves >= int'(CELLS))
            begin
                looped = 1'b1;
                break;
            end
            here = ahead;
            moves++;
        end
        r.spring_cell      = here;
        r.global_id_valid  = on_grid(here);
        r.spring_global_id = (r.global_id_valid && gid_mem.exists(int'(here))) ?
                             gid_mem[int'(here)] : '0;
        r.step_count       = moves[CELL_W-1:0];
        r.loop_error       = looped;
        return r;
    endfunction

    // update the shadow tables or queue the expected spring for one accepted transaction
    task automatic track_item(input item_t t);
        if (t.cmd == CMD_TRACE)
            springs_due.push_back(trace_spring(t.cell_req));
        else if (on_grid(t.cell_req))
        begin
            if (t.cmd == CMD_WR_INFLOW)
                inflow_mem[(int'(t.cell_req) - 1) * SLOTS + int'(t.slot)] = t.neighbour;
            else if (t.cmd == CMD_WR_DISCHARGE)
                discharge_mem[int'(t.cell_req)] = t.value;
            else
                gid_mem[int'(t.cell_req)] = t.value;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_item(input logic [1:0] op, input logic [CELL_W-1:0] c,
                              input logic [SLOT_W-1:0] s, input logic [CELL_W-1:0] nb,
                              input logic [31:0] v);
        pending_t p;
        p.kind         = ENT_ITEM;
        p.it.cmd       = op;
        p.it.cell_req  = c;
        p.it.slot      = s;
        p.it.neighbour = nb;
        p.it.value     = v;
        pend_q.push_back(p);
    endtask

    // fields a trace does not use still carry random bits
    task automatic queue_trace(input logic [CELL_W-1:0] c);
        queue_item(CMD_TRACE, c, SLOT_W'($urandom_range(0, 7)),
                   CELL_W'($urandom_range(0, 131071)), $urandom);
    endtask

    task automatic queue_marker(input entry_kind_t k);
        pending_t p;
        p    = '0;
        p.kind = k;
        pend_q.push_back(p);
    endtask

    function automatic logic is_pool(input logic [CELL_W-1:0] c);
        for (int i = 0; i < POOL_N; i++)
            if (pool[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    // pool order is a DAG: a cell only lists later pool cells, itself, none, or
    // an off-grid cell whose wrapped row still lands on a pool cell
    function automatic logic [CELL_W-1:0] pick_inflow(input int i);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return '0;
        if (r < 7 && i < POOL_N - 1)
            return pool[$urandom_range(i + 1, POOL_N - 1)];
        if (r < 8)
            return pool[i];
        return OFF_GRID + pool[$urandom_range(0, POOL_N - 2)];
    endfunction

    // zero, full scale and tiny values give ties and no-positive cases
    function automatic logic [DIS_W-1:0] pick_discharge();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return '1;
            3, 4, 5: return DIS_W'($urandom_range(1, 3));
            default: return $urandom;
        endcase
    endfunction

    // off-grid start whose wrapped row is still a written pool row
    function automatic logic [CELL_W-1:0] off_grid_start();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return OFF_GRID + pool[$urandom_range(0, POOL_N - 2)];
    endfunction

    task automatic queue_random(input int count);
        int                made;
        int                r;
        int                i;
        logic [1:0]        op;
        logic [CELL_W-1:0] c;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(0, 99);
            i = $urandom_range(0, POOL_N - 1);
            case ($urandom_range(0, 2))
                0:       op = CMD_WR_INFLOW;
                1:       op = CMD_WR_DISCHARGE;
                default: op = CMD_WR_GLOBAL_ID;
            endcase
            if (r < 40)
                queue_trace(pool[i]);
            else if (r < 45)
                queue_trace(off_grid_start());
            else if (r < 65)
                queue_item(CMD_WR_INFLOW, pool[i], SLOT_W'($urandom_range(0, 7)),
                           pick_inflow(i), $urandom);
            else if (r < 75)
                queue_item(CMD_WR_DISCHARGE, pool[i], SLOT_W'($urandom_range(0, 7)),
                           CELL_W'($urandom_range(0, 131071)), pick_discharge());
            else if (r < 80)
                queue_item(CMD_WR_GLOBAL_ID, pool[i], SLOT_W'($urandom_range(0, 7)),
                           CELL_W'($urandom_range(0, 131071)), $urandom);
            else if (r < 92)
            begin
                // on-grid cell outside the pool: written but never read back
                do
                    c = CELL_W'($urandom_range(1, 65536));
                while (is_pool(c));
                queue_item(op, c, SLOT_W'($urandom_range(0, 7)),
                           CELL_W'($urandom_range(0, 131071)), $urandom);
            end
            else
            begin
                // off-grid write, dropped by the block; not counted
                c = ($urandom_range(0, 1) == 0) ? '0 : CELL_W'($urandom_range(65537, 131071));
                queue_item(op, c, SLOT_W'($urandom_range(0, 7)),
                           CELL_W'($urandom_range(0, 131071)), $urandom);
                continue;
            end
            made++;
            if (made % 80 == 79)
                queue_marker(ENT_DRAIN);
        end
    endtask

    // both sides go quiet near the end (under 60 queued) and in every third window of cycle_count
    function automatic logic quiet_now();
        return (pend_q.size() < 60) || ((cycle_count / 500) % 3 == 0);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued transactions, honors drain and hold markers
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            send_gap   = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                track_item(item);
            nxt_valid = item_valid;
            if (!item_valid || item_ready)
            begin
                nxt_valid = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else
                begin
                    // a hold marker starts the long receiver stall, sender keeps going
                    while (pend_q.size() > 0 && pend_q[0].kind == ENT_HOLD)
                    begin
                        hold_asks++;
                        void'(pend_q.pop_front());
                    end
                    if (pend_q.size() > 0 && pend_q[0].kind == ENT_DRAIN)
                    begin
                        // pause until every spring owed has come back
                        if (springs_due.size() == 0)
                            void'(pend_q.pop_front());
                    end
                    else if (pend_q.size() > 0)
                    begin
                        if (!quiet_now() && $urandom_range(0, 5) == 0)
                            send_gap = $urandom_range(0, 8);
                        else
                        begin
                            item      <= pend_q[0].it;
                            nxt_valid = 1'b1;
                            void'(pend_q.pop_front());
                        end
                    end
                end
            end
            item_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts plus the long hold, counted here
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (hold_served != hold_asks)
            begin
                hold_served++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (!quiet_now() && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every accepted result against the oldest spring owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (springs_due.size() == 0)
                flag_mismatch($sformatf("result with nothing owed, spring_cell %0d",
                                        result.spring_cell));
            else
            begin
                want = springs_due.pop_front();
                if (result.spring_cell !== want.spring_cell)
                    flag_mismatch($sformatf("spring_cell got %0d want %0d",
                                            result.spring_cell, want.spring_cell));
                if (result.spring_global_id !== want.spring_global_id)
                    flag_mismatch($sformatf("spring_global_id got %h want %h",
                                            result.spring_global_id, want.spring_global_id));
                if (result.global_id_valid !== want.global_id_valid)
                    flag_mismatch($sformatf("global_id_valid got %b want %b",
                                            result.global_id_valid, want.global_id_valid));
                if (result.step_count !== want.step_count)
                    flag_mismatch($sformatf("step_count got %0d want %0d",
                                            result.step_count, want.step_count));
                if (result.loop_error !== want.loop_error)
                    flag_mismatch($sformatf("loop_error got %b want %b",
                                            result.loop_error, want.loop_error));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [CELL_W-1:0] plan  [POOL_N][SLOTS];
        logic [DIS_W-1:0]  dplan [POOL_N];
        logic [GID_W-1:0]  gplan [POOL_N];

        // pool order matters: inflows only point forward in this list, to the cell itself or off the grid
        for (int i = 0; i < 10; i++)
            pool[i] = CELL_W'(i + 1);
        pool[10] = 17'h05555;
        pool[11] = 17'h0AAAA;
        pool[12] = 17'h0FFFF;
        pool[13] = CELLS;

        for (int i = 0; i < POOL_N; i++)
        begin
            for (int s = 0; s < SLOTS; s++)
                plan[i][s] = '0;
            gplan[i] = $urandom;
        end

        // hand-built upstream network covering each kind of move
        plan[0][7]  = 17'd2;                     // single inflow in the last slot
        plan[1][0]  = 17'd3;                     // several inflows, tie between 4 and 5
        plan[1][1]  = 17'd4;
        plan[1][3]  = 17'd5;
        plan[3][1]  = 17'd6;                     // cell 3 has no inflow at all
        plan[4][0]  = 17'd6;                     // no positive discharge, walk stops
        plan[4][1]  = 17'd7;
        plan[5][0]  = OFF_GRID + 17'd1;          // off-grid inflow counts as zero
        plan[5][1]  = 17'd8;
        plan[6][0]  = 17'h1FFFF;                 // lone off-grid inflow, walk leaves the grid
        plan[7][0]  = 17'd8;                     // best inflow is the cell itself
        plan[7][1]  = 17'd9;
        plan[8][0]  = 17'd10;
        plan[9][2]  = 17'h05555;                 // full-scale tie, lower slot wins
        plan[9][5]  = 17'h0AAAA;
        plan[10][4] = CELLS;
        plan[11][0] = 17'h0FFFF;
        plan[13][7] = CELLS;                     // last cell lists only itself

        dplan[0]  = $urandom;
        dplan[1]  = 32'd12;
        dplan[2]  = 32'd7;
        dplan[3]  = 32'd9;
        dplan[4]  = 32'd9;
        dplan[5]  = '0;
        dplan[6]  = '0;
        dplan[7]  = '1;
        dplan[8]  = 32'd5;
        dplan[9]  = 32'd1;
        dplan[10] = '1;
        dplan[11] = '1;
        dplan[12] = 32'h8000_0000;
        dplan[13] = '0;
        gplan[2]  = '0;
        gplan[12] = '1;

        // every slot, discharge and id of the pool is written before any trace
        for (int i = 0; i < POOL_N; i++)
        begin
            for (int s = 0; s < SLOTS; s++)
                queue_item(CMD_WR_INFLOW, pool[i], SLOT_W'(s), plan[i][s], $urandom);
            queue_item(CMD_WR_DISCHARGE, pool[i], SLOT_W'($urandom_range(0, 7)),
                       CELL_W'($urandom_range(0, 131071)), dplan[i]);
            queue_item(CMD_WR_GLOBAL_ID, pool[i], SLOT_W'($urandom_range(0, 7)),
                       CELL_W'($urandom_range(0, 131071)), gplan[i]);
        end

        // writes off the grid are dropped
        queue_item(CMD_WR_INFLOW, '0, 3'd7, CELLS, '1);
        queue_item(CMD_WR_DISCHARGE, OFF_GRID + 17'd1, 3'd0, '0, '1);
        queue_item(CMD_WR_GLOBAL_ID, 17'h1FFFF, 3'd5, 17'h1FFFF, 32'h0);

        // a trace from every pool cell, then off-grid starts
        for (int i = 0; i < POOL_N; i++)
            queue_trace(pool[i]);
        queue_trace('0);
        queue_trace(OFF_GRID + 17'd1);
        queue_trace(17'h1FFFF);
        queue_trace(OFF_GRID + 17'h05555);
        queue_marker(ENT_DRAIN);

        // long receiver hold while traces keep coming, so the input backs up
        queue_marker(ENT_HOLD);
        for (int k = 0; k < 24; k++)
            queue_trace(pool[$urandom_range(0, POOL_N - 1)]);

        queue_random(170);

        // two cells feeding each other: the walk runs into the step limit
        queue_marker(ENT_DRAIN);
        for (int s = 0; s < SLOTS; s++)
        begin
            queue_item(CMD_WR_INFLOW, 17'h0AAAA, SLOT_W'(s),
                       (s == 0) ? 17'h0FFFF : 17'h0, $urandom);
            queue_item(CMD_WR_INFLOW, 17'h0FFFF, SLOT_W'(s),
                       (s == 0) ? 17'h0AAAA : 17'h0, $urandom);
        end
        queue_trace(17'h0AAAA);
        queue_marker(ENT_DRAIN);
        queue_item(CMD_WR_INFLOW, 17'h0FFFF, 3'd0, 17'h0, $urandom);

        queue_random(200);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (!(pend_q.size() == 0 && !item_valid && springs_due.size() == 0))
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
